FILE: rtl/core/fwow_pkg.sv
// Shared types and constants for the FIFO with ordered waiters.
// No dependencies; every other file of the block imports this package.
package fwow_pkg;

  localparam int ITEM_DEPTH   = 64;
  localparam int WAITER_DEPTH = 16;
  localparam int HANDLE_BITS  = 32;
  localparam int TAG_BITS     = 4;
  localparam int ACTION_BITS  = 2;
  localparam int SERVED_BITS  = 32;

  localparam int ITEM_AW   = $clog2(ITEM_DEPTH);
  localparam int ITEM_CW   = $clog2(ITEM_DEPTH + 1);
  localparam int WAITER_AW = $clog2(WAITER_DEPTH);
  localparam int WAITER_CW = $clog2(WAITER_DEPTH + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int S_DATA_BITS   = ((HANDLE_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int M_PAYLOAD_BITS = HANDLE_BITS + TAG_BITS + ITEM_CW + WAITER_CW + SERVED_BITS;
  localparam int M_DATA_BITS   = ((M_PAYLOAD_BITS + 7) / 8) * 8;

  // Field offsets inside m_tdata, lowest field first.
  localparam int M_TO_LSB     = HANDLE_BITS;
  localparam int M_ICOUNT_LSB = M_TO_LSB + TAG_BITS;
  localparam int M_WCOUNT_LSB = M_ICOUNT_LSB + ITEM_CW;
  localparam int M_SERVED_LSB = M_WCOUNT_LSB + WAITER_CW;

  localparam logic [ACTION_BITS-1:0] ACT_ENQUEUE   = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_BLOCK_DEQ = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_TRY_DEQ   = 2'd2;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_HANDED    = 3'd1,
    ST_STORED    = 3'd2,
    ST_WAITING   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_ENQUEUE,
    CMD_BLOCK_DEQ,
    CMD_TRY_DEQ,
    CMD_INVALID
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [HANDLE_BITS-1:0] handle;
    logic [TAG_BITS-1:0]    tag;
  } cmd_t;

  typedef struct packed {
    status_t                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [TAG_BITS-1:0]    to;
    logic [ITEM_CW-1:0]     item_count;
    logic [WAITER_CW-1:0]   waiter_count;
    logic [SERVED_BITS-1:0] served;
  } result_t;

  typedef enum logic {
    BK_DECIDE,
    BK_READ
  } back_state_t;

endpackage

FILE: rtl/core/fwow_front.sv
// Front part: takes input items and classifies each into a command kind.
// Depends on fwow_pkg.
module fwow_front
  import fwow_pkg::*;
(
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_BITS-1:0] s_tdata,   // item_handle, requester_tag, zero pad
  input  logic [ACTION_BITS-1:0] s_tuser,   // action
  output logic                   push_valid,
  input  logic                   push_ready,
  output cmd_t                   push_cmd
);

  always_comb begin
    push_cmd.handle = s_tdata[HANDLE_BITS-1:0];
    push_cmd.tag    = s_tdata[HANDLE_BITS +: TAG_BITS];
    unique case (s_tuser)
      ACT_ENQUEUE:   push_cmd.kind = CMD_ENQUEUE;
      ACT_BLOCK_DEQ: push_cmd.kind = CMD_BLOCK_DEQ;
      ACT_TRY_DEQ:   push_cmd.kind = CMD_TRY_DEQ;
      default:       push_cmd.kind = CMD_INVALID;
    endcase
  end

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

FILE: rtl/core/fwow_cmdq.sv
// Short command queue between the front and back parts.
// Depends on fwow_pkg.
module fwow_cmdq
  import fwow_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/fwow_back.sv
// Back part: holds the item memory, the waiter line and the counters, carries
// out one command at a time and keeps the result in an output register.
// Depends on fwow_pkg.
module fwow_back
  import fwow_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic [HANDLE_BITS-1:0] item_mem [ITEM_DEPTH];
  logic [TAG_BITS-1:0]    waiter_mem [WAITER_DEPTH];

  back_state_t            state, state_next;
  logic [ITEM_AW-1:0]     item_head, item_head_next;
  logic [ITEM_CW-1:0]     item_fill, item_fill_next;
  logic [WAITER_AW-1:0]   waiter_head, waiter_head_next;
  logic [WAITER_CW-1:0]   waiter_fill, waiter_fill_next;
  logic [SERVED_BITS-1:0] served, served_next;
  logic [TAG_BITS-1:0]    pend_to;
  logic [HANDLE_BITS-1:0] rd_data;

  logic                   item_wr, waiter_wr, rd_en, load_out, out_free;
  result_t                res_next;
  logic [ITEM_AW:0]       item_tail_sum;
  logic [ITEM_AW-1:0]     item_tail, item_head_inc;
  logic [WAITER_AW:0]     waiter_tail_sum;
  logic [WAITER_AW-1:0]   waiter_tail, waiter_head_inc;

  // Tail positions wrap with one compare and subtract, so any depth works.
  always_comb begin
    item_tail_sum = (ITEM_AW + 1)'(item_head) + (ITEM_AW + 1)'(item_fill);
    item_tail     = (item_tail_sum >= (ITEM_AW + 1)'(ITEM_DEPTH)) ?
                    ITEM_AW'(item_tail_sum - (ITEM_AW + 1)'(ITEM_DEPTH)) :
                    ITEM_AW'(item_tail_sum);
    item_head_inc = (item_head == ITEM_AW'(ITEM_DEPTH - 1)) ? '0 : item_head + 1'b1;
    waiter_tail_sum = (WAITER_AW + 1)'(waiter_head) + (WAITER_AW + 1)'(waiter_fill);
    waiter_tail     = (waiter_tail_sum >= (WAITER_AW + 1)'(WAITER_DEPTH)) ?
                      WAITER_AW'(waiter_tail_sum - (WAITER_AW + 1)'(WAITER_DEPTH)) :
                      WAITER_AW'(waiter_tail_sum);
    waiter_head_inc = (waiter_head == WAITER_AW'(WAITER_DEPTH - 1)) ?
                      '0 : waiter_head + 1'b1;
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    item_head_next   = item_head;
    item_fill_next   = item_fill;
    waiter_head_next = waiter_head;
    waiter_fill_next = waiter_fill;
    served_next      = served;
    item_wr          = 1'b0;
    waiter_wr        = 1'b0;
    rd_en            = 1'b0;
    load_out         = 1'b0;
    cmd_ready        = 1'b0;
    res_next         = '0;
    res_next.status  = ST_REJECTED;

    unique case (state)
      BK_DECIDE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          load_out  = 1'b1;
          unique case (cmd.kind)
            CMD_ENQUEUE: begin
              if (waiter_fill != '0) begin
                res_next.status  = ST_HANDED;
                res_next.handle  = cmd.handle;
                res_next.to      = waiter_mem[waiter_head];
                waiter_head_next = waiter_head_inc;
                waiter_fill_next = waiter_fill - 1'b1;
                served_next      = served + 1'b1;
              end else if (item_fill != ITEM_CW'(ITEM_DEPTH)) begin
                res_next.status = ST_STORED;
                item_wr         = 1'b1;
                item_fill_next  = item_fill + 1'b1;
              end
            end
            CMD_BLOCK_DEQ: begin
              if (waiter_fill == '0 && item_fill != '0) begin
                load_out = 1'b0;
                rd_en    = 1'b1;
              end else if (waiter_fill != WAITER_CW'(WAITER_DEPTH)) begin
                res_next.status  = ST_WAITING;
                waiter_wr        = 1'b1;
                waiter_fill_next = waiter_fill + 1'b1;
              end
            end
            CMD_TRY_DEQ: begin
              if (item_fill != '0) begin
                load_out = 1'b0;
                rd_en    = 1'b1;
              end else begin
                res_next.status = ST_EMPTY;
              end
            end
            CMD_INVALID: begin
              res_next.status = ST_REJECTED;
            end
          endcase
          // A handle taken from the store is returned after the memory read.
          if (rd_en) begin
            item_head_next = item_head_inc;
            item_fill_next = item_fill - 1'b1;
            served_next    = served + 1'b1;
            state_next     = BK_READ;
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          load_out        = 1'b1;
          res_next.status = ST_DELIVERED;
          res_next.handle = rd_data;
          res_next.to     = pend_to;
          state_next      = BK_DECIDE;
        end
      end
    endcase

    res_next.item_count   = item_fill_next;
    res_next.waiter_count = waiter_fill_next;
    res_next.served       = served_next;
  end

  always_ff @(posedge clk) begin
    if (item_wr) begin
      item_mem[item_tail] <= cmd.handle;
    end
    if (rd_en) begin
      rd_data <= item_mem[item_head];
    end
  end

  always_ff @(posedge clk) begin
    if (waiter_wr) begin
      waiter_mem[waiter_tail] <= cmd.tag;
    end
    if (rd_en) begin
      pend_to <= cmd.tag;
    end
    if (load_out) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_DECIDE;
      item_head   <= '0;
      item_fill   <= '0;
      waiter_head <= '0;
      waiter_fill <= '0;
      served      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      item_head   <= item_head_next;
      item_fill   <= item_fill_next;
      waiter_head <= waiter_head_next;
      waiter_fill <= waiter_fill_next;
      served      <= served_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/fifo_with_ordered_waiters_unit.sv
// Top level of the FIFO of data handles with an ordered line of waiters.
// Depends on fwow_pkg, fwow_front, fwow_cmdq and fwow_back.
//
// Each item on the slave side is an enqueue, a blocking dequeue or a
// try-dequeue, and each gives exactly one result item on the master side,
// in order. Items are taken into a two-entry command queue whenever it has
// room, so the slave side keeps accepting while a result waits in the
// output register. The back part carries out one command at a time: an
// enqueue, a dequeue that joins the waiter line, an empty try-dequeue or a
// rejected request is finished in the decide state; a dequeue that returns
// a stored handle then passes through the read state for the registered
// read of the item memory. With a free output register, an accepted item
// goes through the command queue and the back part into the output register
// that drives m_tvalid. The handle store holds 64 entries and the waiter
// line 16; at most one of them is nonempty at any time. Handle and waiter
// contents need no clearing after reset, so items are accepted once rst falls.
module fifo_with_ordered_waiters_unit
  import fwow_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_BITS-1:0] s_tdata,   // item_handle, requester_tag, zero pad
  input  logic [ACTION_BITS-1:0] s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata,   // delivered_handle, delivered_to,
                                            // item_count, waiter_count,
                                            // served_count, zero pad
  output logic [2:0]             m_tuser    // status
);

  logic    push_valid, push_ready;
  cmd_t    push_cmd;
  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  result_t res;

  fwow_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fwow_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_cmd    (cmd)
  );

  fwow_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = M_DATA_BITS'({res.served, res.waiter_count, res.item_count,
                                 res.to, res.handle});
  assign m_tuser = res.status;

endmodule

FILE: rtl/core/fwow_checker.sv
// Port-level checks for the FIFO with ordered waiters, bound to the top level.
// Depends on fwow_pkg and fifo_with_ordered_waiters_unit.
module fwow_checker
  import fwow_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [S_DATA_BITS-1:0] s_tdata,
  input logic [ACTION_BITS-1:0] s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_DATA_BITS-1:0] m_tdata,
  input logic [2:0]             m_tuser
);

  logic [ITEM_CW-1:0]   icount;
  logic [WAITER_CW-1:0] wcount;

  assign icount = m_tdata[M_ICOUNT_LSB +: ITEM_CW];
  assign wcount = m_tdata[M_WCOUNT_LSB +: WAITER_CW];

  // An offered item waits unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input item changed while stalled");

  // A result that is held back stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Stored handles and waiting requesters never coexist.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> icount == '0 || wcount == '0)
    else $error("handles stored while requesters wait");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> icount <= ITEM_CW'(ITEM_DEPTH) && wcount <= WAITER_CW'(WAITER_DEPTH))
    else $error("count beyond capacity");

  // An empty report or a new waiter means no handle was left in the store.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_WAITING) |-> icount == '0)
    else $error("empty or waiting reported with handles stored");

endmodule

bind fifo_with_ordered_waiters_unit fwow_checker u_fwow_checker (.*);
